// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file of the impedance point block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");
// Condition must never be true at a rising clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_ALWAYS(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

// ===== hw/rtl/ipc_pkg.sv =====
// Package with widths, codes, item types and helpers of the impedance point block.
package ipc_pkg;

	localparam int COUNT_WIDTH = 16;
	localparam int SWEEP_W = 16;
	localparam int CMP_W = (COUNT_WIDTH + 1 > SWEEP_W) ? COUNT_WIDTH + 1 : SWEEP_W;

	localparam int XW = 32;
	localparam int CW = 48;
	localparam int ZW = 48;
	localparam int LW = 32;
	localparam int AMPW = 32;
	localparam int KW = 64;
	localparam int CFG_IW = 3;
	localparam int CFG_DW = 48;

	// Working width of signed intermediates, and the serial multiplier operands.
	localparam int WW = 168;
	localparam int MAW = 100;
	localparam int MBW = 64;
	localparam int PW = MAW + MBW;

	// Quotient bits produced by the serial divider, one per cycle.
	localparam int QW = ZW;
	localparam int DW = WW + QW - 1;
	localparam int SCW = $clog2(QW + 1);

	localparam logic [CFG_IW-1:0] REG_ADC_LSB   = 3'd0;
	localparam logic [CFG_IW-1:0] REG_DRIVE_PP  = 3'd1;
	localparam logic [CFG_IW-1:0] REG_REF_REAL  = 3'd2;
	localparam logic [CFG_IW-1:0] REG_REF_IMAG  = 3'd3;
	localparam logic [CFG_IW-1:0] REG_CAL_EN    = 3'd4;
	localparam logic [CFG_IW-1:0] REG_SWEEP_PTS = 3'd5;

	localparam logic [1:0] ERR_OK         = 2'd0;
	localparam logic [1:0] ERR_CALIB_ZERO = 2'd1;
	localparam logic [1:0] ERR_NO_CURRENT = 2'd2;

	localparam logic [7:0] DRIVE_SCALE = 8'd250;

	typedef struct packed {
		logic signed [XW-1:0] x_average;
		logic signed [XW-1:0] y_average;
		logic signed [CW-1:0] calib_meas_real;
		logic signed [CW-1:0] calib_meas_imag;
	} ipc_in_t;

	typedef struct packed {
		logic signed [ZW-1:0] impedance_real;
		logic signed [ZW-1:0] impedance_imag;
		logic                 last_point;
		logic [1:0]           error_code;
	} ipc_out_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_st_t;

	// Magnitude of a two's complement working value.
	function automatic logic [WW-1:0] mag_of(logic [WW-1:0] v);
		return v[WW-1] ? (~v + WW'(1)) : v;
	endfunction

	// Drive factor 250 * A * 2^24, kept to its low 64 bits.
	function automatic logic [KW-1:0] drive_k(logic [AMPW-1:0] a);
		logic [AMPW+7:0] p;
		p = (AMPW+8)'(a) * (AMPW+8)'(DRIVE_SCALE);
		return KW'({p, 24'd0});
	endfunction

endpackage

// ===== hw/rtl/ipc_if.sv =====
// Handshake interfaces for the input, result and configuration channels.
interface ipc_in_if;
	import ipc_pkg::*;
	logic    valid;
	logic    ready;
	ipc_in_t item;
	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

interface ipc_out_if;
	import ipc_pkg::*;
	logic     valid;
	logic     ready;
	ipc_out_t item;
	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

interface ipc_cfg_if;
	import ipc_pkg::*;
	logic              valid;
	logic              ready;
	logic [CFG_IW-1:0] index;
	logic [CFG_DW-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/ipc_mul.sv =====
// Serial shift-and-add multiplier on magnitudes, one multiplier bit per cycle.
module ipc_mul (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [ipc_pkg::MAW-1:0] a_mag,
	input  logic [ipc_pkg::MBW-1:0] b_mag,
	output ipc_pkg::unit_st_t     st,
	output logic [ipc_pkg::PW-1:0]  product
);
	import ipc_pkg::*;

	logic          busy_q;
	logic [PW-1:0]  a_q;
	logic [MBW-1:0] b_q;
	logic [PW-1:0]  acc_q;

	// The run ends as soon as no multiplier bits are left.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (busy_q && b_q == '0) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= PW'(a_mag);
			b_q   <= b_mag;
			acc_q <= '0;
		end else if (busy_q && b_q != '0) begin
			if (b_q[0]) begin
				acc_q <= acc_q + a_q;
			end
			a_q <= a_q << 1;
			b_q <= b_q >> 1;
		end
	end

	assign st.busy = busy_q;
	assign st.done = busy_q && (b_q == '0);
	assign product = acc_q;

endmodule

// ===== hw/rtl/ipc_div.sv =====
// Serial restoring divider for two numerators over one divisor, saturating to 48 bits.
module ipc_div (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [ipc_pkg::WW-1:0] num0,
	input  logic [ipc_pkg::WW-1:0] num1,
	input  logic [ipc_pkg::WW-1:0] den,
	output ipc_pkg::unit_st_t      st,
	output logic [ipc_pkg::ZW-1:0] quo0,
	output logic [ipc_pkg::ZW-1:0] quo1
);
	import ipc_pkg::*;

	logic           busy_q;
	logic [SCW-1:0] cnt_q;
	logic [WW-1:0]  r0_q, r1_q;
	logic [DW-1:0]  d_q;
	logic [QW-1:0]  m0_q, m1_q;
	logic           neg0_q, neg1_q;
	logic           ge0, ge1;

	function automatic logic [ZW-1:0] sat_q(logic [QW-1:0] m, logic neg);
		logic [ZW-1:0] r;
		if (m[QW-1]) begin
			r = neg ? {1'b1, {(ZW-1){1'b0}}} : {1'b0, {(ZW-1){1'b1}}};
		end else begin
			r = neg ? (~m + ZW'(1)) : m;
		end
		return r;
	endfunction

	assign ge0 = DW'(r0_q) >= d_q;
	assign ge1 = DW'(r1_q) >= d_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			if (cnt_q == SCW'(QW)) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q + SCW'(1);
			end
		end
	end

	// The top quotient bit doubles as the overflow flag for saturation.
	always_ff @(posedge clk) begin
		if (start) begin
			r0_q   <= mag_of(num0);
			r1_q   <= mag_of(num1);
			neg0_q <= num0[WW-1];
			neg1_q <= num1[WW-1];
			d_q    <= DW'(den) << (QW - 1);
			m0_q   <= '0;
			m1_q   <= '0;
		end else if (busy_q && cnt_q != SCW'(QW)) begin
			if (ge0) begin
				r0_q <= r0_q - d_q[WW-1:0];
			end
			if (ge1) begin
				r1_q <= r1_q - d_q[WW-1:0];
			end
			m0_q <= {m0_q[QW-2:0], ge0};
			m1_q <= {m1_q[QW-2:0], ge1};
			d_q  <= d_q >> 1;
		end
	end

	assign st.busy = busy_q;
	assign st.done = busy_q && (cnt_q == SCW'(QW));
	assign quo0 = sat_q(m0_q, neg0_q);
	assign quo1 = sat_q(m1_q, neg1_q);

endmodule

// ===== hw/rtl/impedance_point_with_calibration.sv =====
// Top level of the impedance point block: registers, sequencer and result register.
//
// Each accepted item carries one lock-in pair (x, y) and the calibration measurement
// of the same sweep point; the block returns one result item with the impedance in
// signed Q32.16 kilo-ohms, a last-point flag and an error code. The impedance is
// 250 * drive * 2^24 * (y - jx) / (lsb * (x*x + y*y)), and with calibration enabled
// it is further multiplied by reference / measurement; every quotient truncates
// toward zero and saturates to 48 bits. An all-zero calibration measurement (when
// enabled) or a zero current gives zeros with an error code. One item is worked on
// at a time: a shared serial multiplier takes one multiplier bit per cycle and a
// serial divider produces both 48-bit quotient parts bit by bit. An item without
// calibration takes five multiplies and one division; with calibration ten more
// multiplies of up to 48 multiplier bits and a second division follow. An item
// that ends in an error goes from the input straight to the output register. The
// next item is accepted as soon as the result is in the output register, even if
// not yet taken. Configuration writes are always accepted and must be made while
// the block is idle.
module impedance_point_with_calibration (
	input logic     clk,
	input logic     arst_n,
	ipc_cfg_if.sink cfg,
	ipc_in_if.sink  sample,
	ipc_out_if.source result
);
	import ipc_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_MUL  = 4'b0010,
		S_DIV  = 4'b0100,
		S_OUT  = 4'b1000
	} state_t;

	// Sequencer steps; each multiply step names its operands and destination.
	localparam logic [4:0] ST_XX      = 5'd0;
	localparam logic [4:0] ST_YY      = 5'd1;
	localparam logic [4:0] ST_DEN     = 5'd2;
	localparam logic [4:0] ST_NR      = 5'd3;
	localparam logic [4:0] ST_NI      = 5'd4;
	localparam logic [4:0] ST_DIV_RAW = 5'd5;
	localparam logic [4:0] ST_PR_A    = 5'd6;
	localparam logic [4:0] ST_PR_B    = 5'd7;
	localparam logic [4:0] ST_PI_A    = 5'd8;
	localparam logic [4:0] ST_PI_B    = 5'd9;
	localparam logic [4:0] ST_C2_A    = 5'd10;
	localparam logic [4:0] ST_C2_B    = 5'd11;
	localparam logic [4:0] ST_NR_A    = 5'd12;
	localparam logic [4:0] ST_NR_B    = 5'd13;
	localparam logic [4:0] ST_NI_A    = 5'd14;
	localparam logic [4:0] ST_NI_B    = 5'd15;
	localparam logic [4:0] ST_DIV_CAL = 5'd16;

	localparam logic [1:0] M_LOAD  = 2'd0;
	localparam logic [1:0] M_ADD   = 2'd1;
	localparam logic [1:0] M_SUB   = 2'd2;
	localparam logic [1:0] M_NLOAD = 2'd3;

	localparam logic [2:0] D_DEN = 3'd0;
	localparam logic [2:0] D_NR  = 3'd1;
	localparam logic [2:0] D_NI  = 3'd2;
	localparam logic [2:0] D_PR  = 3'd3;
	localparam logic [2:0] D_PI  = 3'd4;

	// Configuration registers.
	logic [LW-1:0]      lsb_q;
	logic [AMPW-1:0]    amp_q;
	logic [CW-1:0]      ref_re_q, ref_im_q;
	logic               cal_en_q;
	logic [SWEEP_W-1:0] sweep_q;

	state_t                 state_q;
	logic [4:0]             step_q;
	logic                   mul_start_q, div_start_q, mul_neg_q;
	logic [COUNT_WIDTH-1:0] cnt_q;
	logic                   out_valid_q;
	ipc_out_t               out_item_q;

	logic [XW-1:0] x_q, y_q;
	logic [CW-1:0] cr_q, ci_q;
	logic [WW-1:0] den_q, nr_q, ni_q, pr_q, pi_q;
	logic [ZW-1:0] zr_q, zi_q;
	logic [1:0]    err_q;
	logic          last_q;

	logic                 acc_in, out_load;
	logic [1:0]           err_in;
	logic [COUNT_WIDTH:0] cnt_next;
	logic                 last_in;
	logic [WW-1:0]        opa, opb, p_s, cur, upd;
	logic [WW-1:0]        opa_mag, opb_mag;
	logic [1:0]           mode;
	logic [2:0]           dest;
	logic [KW-1:0]        k_val;
	logic [PW-1:0]        product;
	logic [ZW-1:0]        quo0, quo1;
	unit_st_t             mul_st, div_st;

	assign cfg.ready = 1'b1;
	assign sample.ready = (state_q == S_IDLE);
	assign acc_in = sample.valid && sample.ready;
	assign out_load = (state_q == S_OUT) && (!out_valid_q || result.ready);

	assign result.valid = out_valid_q;
	assign result.item = out_item_q;

	// The calibration check takes priority over the zero-current check.
	always_comb begin
		if (cal_en_q && sample.item.calib_meas_real == '0
				&& sample.item.calib_meas_imag == '0) begin
			err_in = ERR_CALIB_ZERO;
		end else if ((sample.item.x_average == '0 && sample.item.y_average == '0)
				|| lsb_q == '0) begin
			err_in = ERR_NO_CURRENT;
		end else begin
			err_in = ERR_OK;
		end
	end

	assign cnt_next = {1'b0, cnt_q} + (COUNT_WIDTH+1)'(1);
	assign last_in = CMP_W'(cnt_next) >= CMP_W'(sweep_q);

	assign k_val = drive_k(amp_q);

	// Operand selection for the current multiply step.
	always_comb begin
		opa = '0;
		opb = '0;
		mode = M_LOAD;
		dest = D_DEN;
		case (step_q)
			ST_XX: begin
				opa = {{(WW-XW){x_q[XW-1]}}, x_q};
				opb = {{(WW-XW){x_q[XW-1]}}, x_q};
			end
			ST_YY: begin
				opa = {{(WW-XW){y_q[XW-1]}}, y_q};
				opb = {{(WW-XW){y_q[XW-1]}}, y_q};
				mode = M_ADD;
			end
			ST_DEN: begin
				opa = WW'(lsb_q);
				opb = den_q;
			end
			ST_NR: begin
				opa = WW'(k_val);
				opb = {{(WW-XW){y_q[XW-1]}}, y_q};
				dest = D_NR;
			end
			ST_NI: begin
				opa = WW'(k_val);
				opb = {{(WW-XW){x_q[XW-1]}}, x_q};
				mode = M_NLOAD;
				dest = D_NI;
			end
			ST_PR_A: begin
				opa = {{(WW-ZW){zr_q[ZW-1]}}, zr_q};
				opb = {{(WW-CW){ref_re_q[CW-1]}}, ref_re_q};
				dest = D_PR;
			end
			ST_PR_B: begin
				opa = {{(WW-ZW){zi_q[ZW-1]}}, zi_q};
				opb = {{(WW-CW){ref_im_q[CW-1]}}, ref_im_q};
				mode = M_SUB;
				dest = D_PR;
			end
			ST_PI_A: begin
				opa = {{(WW-ZW){zr_q[ZW-1]}}, zr_q};
				opb = {{(WW-CW){ref_im_q[CW-1]}}, ref_im_q};
				dest = D_PI;
			end
			ST_PI_B: begin
				opa = {{(WW-ZW){zi_q[ZW-1]}}, zi_q};
				opb = {{(WW-CW){ref_re_q[CW-1]}}, ref_re_q};
				mode = M_ADD;
				dest = D_PI;
			end
			ST_C2_A: begin
				opa = {{(WW-CW){cr_q[CW-1]}}, cr_q};
				opb = {{(WW-CW){cr_q[CW-1]}}, cr_q};
			end
			ST_C2_B: begin
				opa = {{(WW-CW){ci_q[CW-1]}}, ci_q};
				opb = {{(WW-CW){ci_q[CW-1]}}, ci_q};
				mode = M_ADD;
			end
			ST_NR_A: begin
				opa = pr_q;
				opb = {{(WW-CW){cr_q[CW-1]}}, cr_q};
				dest = D_NR;
			end
			ST_NR_B: begin
				opa = pi_q;
				opb = {{(WW-CW){ci_q[CW-1]}}, ci_q};
				mode = M_ADD;
				dest = D_NR;
			end
			ST_NI_A: begin
				opa = pi_q;
				opb = {{(WW-CW){cr_q[CW-1]}}, cr_q};
				dest = D_NI;
			end
			ST_NI_B: begin
				opa = pr_q;
				opb = {{(WW-CW){ci_q[CW-1]}}, ci_q};
				mode = M_SUB;
				dest = D_NI;
			end
			default: begin
				opa = '0;
			end
		endcase
	end

	// Signed product, then accumulate into the destination register.
	assign p_s = mul_neg_q ? (~WW'(product) + WW'(1)) : WW'(product);

	always_comb begin
		case (dest)
			D_NR:    cur = nr_q;
			D_NI:    cur = ni_q;
			D_PR:    cur = pr_q;
			D_PI:    cur = pi_q;
			default: cur = den_q;
		endcase
		case (mode)
			M_ADD:   upd = cur + p_s;
			M_SUB:   upd = cur - p_s;
			M_NLOAD: upd = ~p_s + WW'(1);
			default: upd = p_s;
		endcase
	end

	// The multiplier works on magnitudes; the sign is applied to its product.
	assign opa_mag = mag_of(opa);
	assign opb_mag = mag_of(opb);

	ipc_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start_q),
		.a_mag   (opa_mag[MAW-1:0]),
		.b_mag   (opb_mag[MBW-1:0]),
		.st      (mul_st),
		.product (product)
	);

	ipc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start_q),
		.num0   (nr_q),
		.num1   (ni_q),
		.den    (den_q),
		.st     (div_st),
		.quo0   (quo0),
		.quo1   (quo1)
	);

	// Configuration registers take a write whenever the channel presents one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lsb_q    <= LW'(32'd16777216);
			amp_q    <= AMPW'(32'd65536);
			ref_re_q <= CW'(48'd65536);
			ref_im_q <= '0;
			cal_en_q <= 1'b0;
			sweep_q  <= SWEEP_W'(1);
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_ADC_LSB:   lsb_q    <= cfg.data[LW-1:0];
				REG_DRIVE_PP:  amp_q    <= cfg.data[AMPW-1:0];
				REG_REF_REAL:  ref_re_q <= cfg.data[CW-1:0];
				REG_REF_IMAG:  ref_im_q <= cfg.data[CW-1:0];
				REG_CAL_EN:    cal_en_q <= cfg.data[0];
				REG_SWEEP_PTS: sweep_q  <= cfg.data[SWEEP_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Sequencer: multiply steps, then a division, optionally the calibration pass.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= ST_XX;
			mul_start_q <= 1'b0;
			div_start_q <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			mul_start_q <= 1'b0;
			div_start_q <= 1'b0;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (acc_in) begin
						cnt_q <= last_in ? '0 : cnt_next[COUNT_WIDTH-1:0];
						if (err_in != ERR_OK) begin
							state_q <= S_OUT;
						end else begin
							step_q      <= ST_XX;
							mul_start_q <= 1'b1;
							state_q     <= S_MUL;
						end
					end
				end
				S_MUL: begin
					if (mul_st.done) begin
						step_q <= step_q + 5'd1;
						if (step_q + 5'd1 == ST_DIV_RAW || step_q + 5'd1 == ST_DIV_CAL) begin
							div_start_q <= 1'b1;
							state_q     <= S_DIV;
						end else begin
							mul_start_q <= 1'b1;
						end
					end
				end
				S_DIV: begin
					if (div_st.done) begin
						if (step_q == ST_DIV_RAW && cal_en_q) begin
							step_q      <= ST_PR_A;
							mul_start_q <= 1'b1;
							state_q     <= S_MUL;
						end else begin
							state_q <= S_OUT;
						end
					end
				end
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Working registers carry no reset.
	always_ff @(posedge clk) begin
		if (acc_in) begin
			x_q    <= sample.item.x_average;
			y_q    <= sample.item.y_average;
			cr_q   <= sample.item.calib_meas_real;
			ci_q   <= sample.item.calib_meas_imag;
			err_q  <= err_in;
			last_q <= last_in;
			zr_q   <= '0;
			zi_q   <= '0;
		end
		if (mul_start_q) begin
			mul_neg_q <= opa[WW-1] ^ opb[WW-1];
		end
		if (state_q == S_MUL && mul_st.done) begin
			case (dest)
				D_NR:    nr_q  <= upd;
				D_NI:    ni_q  <= upd;
				D_PR:    pr_q  <= upd;
				D_PI:    pi_q  <= upd;
				default: den_q <= upd;
			endcase
		end
		if (state_q == S_DIV && div_st.done) begin
			zr_q <= quo0;
			zi_q <= quo1;
		end
		if (out_load) begin
			out_item_q.impedance_real <= zr_q;
			out_item_q.impedance_imag <= zi_q;
			out_item_q.last_point     <= last_q;
			out_item_q.error_code     <= err_q;
		end
	end

	`include "assert_macros.svh"

	// The multiplier and the divider never run at the same time.
	`ASSERT_NEVER(a_units_exclusive, clk, arst_n, mul_st.busy && div_st.busy)
	// A flagged result always carries a zero impedance.
	`ASSERT_ALWAYS(a_err_zero, clk, arst_n, (result.valid && result.item.error_code != ERR_OK) |-> (result.item.impedance_real == '0 && result.item.impedance_imag == '0))
	// A last point leaves the point counter at zero until the next item.
	`ASSERT_ALWAYS(a_last_wraps, clk, arst_n, (state_q == S_OUT && last_q) |-> (cnt_q == '0))

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for the impedance point block with calibration.
`timescale 1ns / 1ps

module tb_top;
	import ipc_pkg::*;

	typedef logic signed [255:0] wide_t;

	// One row of the directed table. When typed is set, the row carries its own
	// expected result. Otherwise the expected result comes from the point model.
	typedef struct {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [47:0] cre;
		logic signed [47:0] cim;
		bit                 typed;
		ipc_out_t           want;
	} point_row_t;

	logic clk;
	logic arst_n;

	ipc_cfg_if cfg ();
	ipc_in_if  sample ();
	ipc_out_if result ();

	impedance_point_with_calibration dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg.sink),
		.sample (sample.sink),
		.result (result.source)
	);

	// The clock period is 12 ns.
	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Shadow copy of the configuration registers and the sweep point counter.
	logic [31:0] lsb_cur;
	logic [31:0] drive_pp;
	logic signed [47:0] ref_re;
	logic signed [47:0] ref_im;
	logic cal_on;
	logic [15:0] sweep_len;
	logic [15:0] point_idx;

	ipc_out_t impedance_q[$];
	int mismatches = 0;
	bit calm = 0;
	int stall_left = 0;

	// Clamp a wide signed quotient to the 48-bit signed range of the outputs.
	function automatic logic signed [47:0] clamp48(wide_t q);
		wide_t hi;
		wide_t lo;
		hi = (wide_t'(1) <<< 47) - 1;
		lo = -(wide_t'(1) <<< 47);
		if (q > hi) return hi[47:0];
		if (q < lo) return lo[47:0];
		return q[47:0];
	endfunction

	// Work out the result of one sweep point and advance the point counter.
	// The division truncates toward zero, which is what signed / does here.
	function automatic ipc_out_t impedance_of(ipc_in_t s);
		ipc_out_t o;
		logic [63:0] kk;
		logic [16:0] nxt;
		wide_t wk, wx, wy, den, a, b, rr, ri, cr, ci, pr, pi, c2;
		o = '0;
		o.error_code = ERR_OK;
		if (cal_on && s.calib_meas_real == 0 && s.calib_meas_imag == 0) begin
			o.error_code = ERR_CALIB_ZERO;
		end else if ((s.x_average == 0 && s.y_average == 0) || lsb_cur == 0) begin
			o.error_code = ERR_NO_CURRENT;
		end else begin
			// The drive factor lives in 64 bits and wraps, as in the block.
			kk = (64'(drive_pp) * 64'd250) << 24;
			wk = {192'd0, kk};
			wx = s.x_average;
			wy = s.y_average;
			den = {224'd0, lsb_cur} * (wx * wx + wy * wy);
			o.impedance_real = clamp48((wk * wy) / den);
			o.impedance_imag = clamp48((-(wk * wx)) / den);
			if (cal_on) begin
				a = o.impedance_real;
				b = o.impedance_imag;
				rr = ref_re;
				ri = ref_im;
				cr = s.calib_meas_real;
				ci = s.calib_meas_imag;
				pr = a * rr - b * ri;
				pi = a * ri + b * rr;
				c2 = cr * cr + ci * ci;
				o.impedance_real = clamp48((pr * cr + pi * ci) / c2);
				o.impedance_imag = clamp48((pi * cr - pr * ci) / c2);
			end
		end
		// The counter marks the final point of a sweep and then starts over.
		nxt = {1'b0, point_idx} + 17'd1;
		if (nxt >= {1'b0, sweep_len}) begin
			o.last_point = 1'b1;
			point_idx = '0;
		end else begin
			o.last_point = 1'b0;
			point_idx = nxt[15:0];
		end
		return o;
	endfunction

	// Result side: random stall bursts, none in the last phase.
	always @(negedge clk) begin
		if (calm) begin
			result.ready = 1'b1;
		end else if (stall_left > 0) begin
			result.ready = 1'b0;
			stall_left--;
		end else begin
			result.ready = 1'b1;
			if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 13);
		end
	end

	// Every accepted result is compared, field by field, with the oldest
	// expectation in the queue.
	always @(posedge clk) begin
		ipc_out_t got;
		ipc_out_t exp_r;
		if (arst_n && result.valid && result.ready) begin
			got = result.item;
			if (impedance_q.size() == 0) begin
				$error("result item with nothing expected");
				mismatches++;
			end else begin
				exp_r = impedance_q.pop_front();
				if (got.impedance_real !== exp_r.impedance_real) begin
					$error("impedance_real expected %0d got %0d",
						exp_r.impedance_real, got.impedance_real);
					mismatches++;
				end
				if (got.impedance_imag !== exp_r.impedance_imag) begin
					$error("impedance_imag expected %0d got %0d",
						exp_r.impedance_imag, got.impedance_imag);
					mismatches++;
				end
				if (got.last_point !== exp_r.last_point) begin
					$error("last_point expected %0d got %0d",
						exp_r.last_point, got.last_point);
					mismatches++;
				end
				if (got.error_code !== exp_r.error_code) begin
					$error("error_code expected %0d got %0d",
						exp_r.error_code, got.error_code);
					mismatches++;
				end
			end
		end
	end

	// Offer one item at the falling edge and hold it until it is accepted.
	// Valid stays high into the next item unless an idle burst is drawn.
	task automatic send_point(ipc_in_t s, bit typed, ipc_out_t want);
		ipc_out_t pred;
		int gap;
		if (!calm && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 13);
			sample.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		sample.valid = 1'b1;
		sample.item = s;
		@(posedge clk);
		while (!sample.ready) @(posedge clk);
		pred = impedance_of(s);
		impedance_q.push_back(typed ? want : pred);
		@(negedge clk);
	endtask

	// Wait until every expected result has come back.
	task automatic drain();
		sample.valid = 1'b0;
		while (impedance_q.size() != 0) @(negedge clk);
	endtask

	// Register writes happen only with the block idle, so the shadow copy can
	// be updated at the moment of the write.
	task automatic write_reg(logic [CFG_IW-1:0] idx, logic [47:0] val);
		drain();
		cfg.valid = 1'b1;
		cfg.index = idx;
		cfg.data = val;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		case (idx)
			REG_ADC_LSB:   lsb_cur = val[31:0];
			REG_DRIVE_PP:  drive_pp = val[31:0];
			REG_REF_REAL:  ref_re = val;
			REG_REF_IMAG:  ref_im = val;
			REG_CAL_EN:    cal_on = val[0];
			REG_SWEEP_PTS: sweep_len = val[15:0];
			default: ;
		endcase
		@(negedge clk);
		cfg.valid = 1'b0;
	endtask

	function automatic logic [47:0] rand48();
		logic [63:0] r;
		r = {$urandom(), $urandom()};
		return r[47:0];
	endfunction

	function automatic point_row_t mk_row(logic signed [31:0] x, logic signed [31:0] y,
		logic signed [47:0] cre, logic signed [47:0] cim);
		point_row_t r;
		r.x = x;
		r.y = y;
		r.cre = cre;
		r.cim = cim;
		r.typed = 0;
		r.want = '0;
		return r;
	endfunction

	function automatic point_row_t mk_typed(logic signed [31:0] x, logic signed [31:0] y,
		logic signed [47:0] cre, logic signed [47:0] cim, logic signed [47:0] zr,
		logic signed [47:0] zi, logic [1:0] ec, logic lp);
		point_row_t r;
		r = mk_row(x, y, cre, cim);
		r.typed = 1;
		r.want.impedance_real = zr;
		r.want.impedance_imag = zi;
		r.want.last_point = lp;
		r.want.error_code = ec;
		return r;
	endfunction

	// Random point: moderate or full-range values, plus one-axis, zero-current and
	// unit-size pairs. The calibration measurement is usually near 1 kOhm so
	// the corrected result stays in range, with full-range and zero cases too.
	function automatic ipc_in_t rand_point();
		ipc_in_t s;
		int unsigned pick;
		pick = $urandom_range(0, 9);
		if (pick < 4) begin
			s.x_average = $signed($urandom_range(0, 2000)) - 1000;
			s.y_average = $signed($urandom_range(0, 2000)) - 1000;
		end else if (pick < 7) begin
			s.x_average = $urandom();
			s.y_average = $urandom();
		end else if (pick == 7) begin
			s.x_average = $urandom_range(0, 1) ? 32'sd0 : $signed($urandom());
			s.y_average = (s.x_average == 0) ? $signed($urandom()) : 32'sd0;
		end else if (pick == 8) begin
			s.x_average = 0;
			s.y_average = 0;
		end else begin
			s.x_average = $urandom_range(0, 1) ? 32'sd1 : -32'sd1;
			s.y_average = $urandom_range(0, 1) ? 32'sd1 : -32'sd1;
		end
		pick = $urandom_range(0, 19);
		if (pick < 12) begin
			s.calib_meas_real = 48'sd65536 + $signed($urandom_range(0, 60000)) - 30000;
			s.calib_meas_imag = $signed($urandom_range(0, 60000)) - 30000;
		end else if (pick < 18) begin
			s.calib_meas_real = rand48();
			s.calib_meas_imag = rand48();
		end else if (pick == 18) begin
			s.calib_meas_real = 0;
			s.calib_meas_imag = $urandom_range(0, 1) ? 48'sd0 : 48'sd1;
		end else begin
			s.calib_meas_real = 0;
			s.calib_meas_imag = 0;
		end
		return s;
	endfunction

	// Stimulus: a directed table under two settings, then random phases.
	initial begin
		point_row_t rows[$];
		ipc_in_t s;
		ipc_out_t none;
		logic [31:0] v32;
		logic [47:0] v48;
		int split;
		none = '0;
		arst_n = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		sample.valid = 1'b0;
		sample.item = '0;
		result.ready = 1'b0;
		lsb_cur = 32'd16777216;
		drive_pp = 32'd65536;
		ref_re = 48'sd65536;
		ref_im = 48'sd0;
		cal_on = 1'b0;
		sweep_len = 16'd1;
		point_idx = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset settings: 1 uA per LSB, 1 V peak to peak, no calibration, and a
		// sweep of one point, so every result is a last point. A unit current
		// then gives 250 * 2^16 in Q32.16.
		rows.push_back(mk_typed(0, 0, 0, 0, 0, 0, ERR_NO_CURRENT, 1'b1));
		rows.push_back(mk_typed(0, 1, 0, 0, 48'sd16384000, 0, ERR_OK, 1'b1));
		rows.push_back(mk_typed(-1, 0, 7, 9, 0, 48'sd16384000, ERR_OK, 1'b1));
		rows.push_back(mk_typed(0, -1, 0, 0, -48'sd16384000, 0, ERR_OK, 1'b1));
		rows.push_back(mk_row(32'sh7FFFFFFF, 32'sh7FFFFFFF, 0, 0));
		rows.push_back(mk_row(32'sh80000000, 32'sh80000000, 0, 0));
		rows.push_back(mk_row(32'sh80000000, 0, 48'sh800000000000, 0));
		rows.push_back(mk_row(0, 32'sh7FFFFFFF, 0, 48'sh7FFFFFFFFFFF));
		rows.push_back(mk_row(1, -1, 0, 0));
		rows.push_back(mk_row(12345, -678, 0, 0));
		split = rows.size();
		// Calibration on: an all-zero measurement wins over a zero current.
		// The sweep is three points long, so only the third row ends it.
		rows.push_back(mk_typed(0, 0, 0, 0, 0, 0, ERR_CALIB_ZERO, 1'b0));
		rows.push_back(mk_typed(100, 5, 0, 0, 0, 0, ERR_CALIB_ZERO, 1'b0));
		rows.push_back(mk_typed(0, 0, 65536, 0, 0, 0, ERR_NO_CURRENT, 1'b1));
		rows.push_back(mk_row(0, 1, 65536, 0));
		rows.push_back(mk_row(-1, 0, 0, 65536));
		rows.push_back(mk_row(1, 1, 48'sh7FFFFFFFFFFF, 48'sh7FFFFFFFFFFF));
		rows.push_back(mk_row(1, 1, 48'sh800000000000, 48'sh800000000000));
		rows.push_back(mk_row(1, 0, 1, 0));
		rows.push_back(mk_row(32'sh7FFFFFFF, 32'sh80000000, 0, -1));
		rows.push_back(mk_row(300, 400, 65536, 65536));

		for (int i = 0; i < rows.size(); i++) begin
			if (i == split) begin
				write_reg(REG_CAL_EN, 48'd1);
				write_reg(REG_SWEEP_PTS, 48'd3);
			end
			s.x_average = rows[i].x;
			s.y_average = rows[i].y;
			s.calib_meas_real = rows[i].cre;
			s.calib_meas_imag = rows[i].cim;
			send_point(s, rows[i].typed, rows[i].want);
		end

		// Random phases, each with its own settings; extremes come in turn.
		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 5)
				0: v32 = 32'd1;
				1: v32 = 32'hFFFFFFFF;
				2: v32 = (ph == 7) ? 32'd0 : 32'd16777216;
				default: v32 = $urandom();
			endcase
			write_reg(REG_ADC_LSB, {16'd0, v32});
			case (ph % 4)
				0: v32 = 32'hFFFFFFFF;
				1: v32 = 32'd0;
				2: v32 = 32'd65536;
				default: v32 = $urandom();
			endcase
			write_reg(REG_DRIVE_PP, {16'd0, v32});
			case (ph % 4)
				0: v48 = 48'h7FFFFFFFFFFF;
				1: v48 = 48'h800000000000;
				2: v48 = 48'sd65536 + $urandom_range(0, 1000);
				default: v48 = rand48();
			endcase
			write_reg(REG_REF_REAL, v48);
			case ((ph + 1) % 4)
				0: v48 = 48'h7FFFFFFFFFFF;
				1: v48 = 48'h800000000000;
				2: v48 = $urandom_range(0, 1000);
				default: v48 = rand48();
			endcase
			write_reg(REG_REF_IMAG, v48);
			write_reg(REG_CAL_EN, (ph % 2 == 0) ? 48'd1 : 48'd0);
			case (ph % 4)
				0: v32 = 32'd65535;
				1: v32 = 32'd1;
				2: v32 = 32'd3;
				default: v32 = $urandom_range(2, 20);
			endcase
			write_reg(REG_SWEEP_PTS, {16'd0, v32});
			// The last phase runs with no idling on either side.
			if (ph == 7) calm = 1;
			for (int n = 0; n < 200; n++) begin
				// Once, the sender holds off until the block has returned everything.
				if (ph == 3 && n == 100) drain();
				send_point(rand_point(), 0, none);
			end
		end
		drain();
		repeat (50) @(posedge clk);
		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#100ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
